// ----- rtl/cc20d_pkg.sv -----
// shared types and constants for the chacha20 fast key erasure generator
package cc20d_pkg;

    localparam logic [31:0] SIGMA0 = 32'h61707865;
    localparam logic [31:0] SIGMA1 = 32'h3320646e;
    localparam logic [31:0] SIGMA2 = 32'h79622d32;
    localparam logic [31:0] SIGMA3 = 32'h6b206574;

    localparam int BLOCK_BYTES = 64;
    localparam int KEY_BYTES   = 32;

    localparam logic CMD_FOLD = 1'b0;
    localparam logic CMD_GEN  = 1'b1;

    // classified command handed from front to back
    typedef struct packed {
        logic        gen;
        logic [7:0]  ebyte;
        logic        elast;
        logic        emark;
        logic [8:0]  nbytes;
        logic [31:0] tick;
    } cmd_t;

    function automatic logic [31:0] rotl(input logic [31:0] v, input int s);
        rotl = (v << s) | (v >> (32 - s));
    endfunction

endpackage

// ----- rtl/chacha20_drbg_fast_key_erasure_unit.sv -----
// top level of the chacha20 fast key erasure random generator
//  channel | dir | tdata                               | tuser / tlast
//  s_      | in  | entropy_byte, request_bytes, now_ms | cmd, mark_seeded / entropy_last
//  m_      | out | keystream_word, byte_count          | none / last_word
// a block in the round core is 20 rounds plus load and add
// fold byte: xor into key; last byte: also a mix block; output block: up to 16 words
// reset clears key, counter, seeded flag and entropy position
// results stall only the back end; the two-entry front queue takes items until full
module chacha20_drbg_fast_key_erasure_unit #(
    parameter int MAX_REQUEST_BYTES = 256
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,  // entropy_byte, request_bytes, now_ms
    input  logic [7:0]  s_tuser,  // cmd, mark_seeded
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,  // keystream_word, byte_count
    output logic        m_tlast
);

    cc20d_pkg::cmd_t q_data;
    logic q_valid;
    logic q_ready;

    cc20d_front #(.MAX_REQUEST_BYTES(MAX_REQUEST_BYTES)) u_front (
        .aclk(aclk), .aresetn(aresetn), .s_tvalid(s_tvalid), .s_tready(s_tready),
        .s_tuser(s_tuser), .s_tlast(s_tlast), .s_tdata(s_tdata), .q_data(q_data),
        .q_valid(q_valid), .q_ready(q_ready)
    );

    cc20d_back u_back (
        .aclk(aclk), .aresetn(aresetn), .q_data(q_data), .q_valid(q_valid),
        .q_ready(q_ready), .m_tvalid(m_tvalid), .m_tready(m_tready),
        .m_tdata(m_tdata), .m_tlast(m_tlast)
    );

endmodule

// ----- rtl/cc20d_front.sv -----
// input stage: accepts items, saturates the request length and queues commands
module cc20d_front #(
    parameter int MAX_REQUEST_BYTES = 256
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  logic [7:0]     s_tuser,
    input  logic           s_tlast,
    input  logic [55:0]    s_tdata,
    output cc20d_pkg::cmd_t q_data,
    output logic           q_valid,
    input  logic           q_ready
);

    localparam logic [8:0] MAXB = 9'(MAX_REQUEST_BYTES);

    cc20d_pkg::cmd_t slot_reg [2];
    logic [1:0] cnt_reg;
    logic       wr_reg;
    logic       rd_reg;
    cc20d_pkg::cmd_t c;
    logic push;
    logic pop;

    always_comb begin
        c.gen    = s_tuser[0];
        c.elast  = s_tlast;
        c.emark  = s_tuser[1];
        c.ebyte  = s_tdata[7:0];
        c.nbytes = (s_tdata[16:8] > MAXB) ? MAXB : s_tdata[16:8];
        c.tick   = s_tdata[48:17];
    end

    assign s_tready = (cnt_reg != 2'd2);
    assign push     = s_tvalid && s_tready;
    assign q_valid  = (cnt_reg != 2'd0);
    assign pop      = q_valid && q_ready;
    assign q_data   = slot_reg[rd_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_reg] <= c;
        end
        if (!aresetn) begin
            cnt_reg <= '0;
            wr_reg  <= 1'b0;
            rd_reg  <= 1'b0;
        end else begin
            if (push) wr_reg <= ~wr_reg;
            if (pop)  rd_reg <= ~rd_reg;
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end

    a_cnt: assert property (@(posedge aclk) disable iff (!aresetn) cnt_reg <= 2'd2)
        else $error("queue count overflow");
    a_pop: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg == 2'd0 && !push) |=> (cnt_reg == 2'd0))
        else $error("queue count changed without push");
    a_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg == 2'd2) |-> !s_tready)
        else $error("ready while full");

endmodule

// ----- rtl/cc20d_core.sv -----
// chacha20 block unit: one round per cycle, column and diagonal rounds alternate
module cc20d_core (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         start,
    input  logic [255:0] key,
    input  logic [63:0]  ctr,
    output logic         done,
    output logic [511:0] blk
);

    logic [31:0] s_reg [16];
    logic [31:0] i_reg [16];
    logic [31:0] xc [16];
    logic [31:0] xd [16];
    logic [4:0]  rnd_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [31:0] init [16];

    function automatic void qr(inout logic [31:0] a, inout logic [31:0] b,
                               inout logic [31:0] c, inout logic [31:0] d);
        a = a + b; d = cc20d_pkg::rotl(d ^ a, 16);
        c = c + d; b = cc20d_pkg::rotl(b ^ c, 12);
        a = a + b; d = cc20d_pkg::rotl(d ^ a, 8);
        c = c + d; b = cc20d_pkg::rotl(b ^ c, 7);
    endfunction

    assign done = done_reg;

    always_comb begin
        init[0] = cc20d_pkg::SIGMA0;
        init[1] = cc20d_pkg::SIGMA1;
        init[2] = cc20d_pkg::SIGMA2;
        init[3] = cc20d_pkg::SIGMA3;
        for (int k = 0; k < 8; k++) init[4+k] = key[32*k +: 32];
        init[12] = ctr[31:0];
        init[13] = ctr[63:32];
        init[14] = '0;
        init[15] = '0;
        for (int k = 0; k < 16; k++) xc[k] = s_reg[k];
        qr(xc[0], xc[4], xc[8],  xc[12]);
        qr(xc[1], xc[5], xc[9],  xc[13]);
        qr(xc[2], xc[6], xc[10], xc[14]);
        qr(xc[3], xc[7], xc[11], xc[15]);
        for (int k = 0; k < 16; k++) xd[k] = s_reg[k];
        qr(xd[0], xd[5], xd[10], xd[15]);
        qr(xd[1], xd[6], xd[11], xd[12]);
        qr(xd[2], xd[7], xd[8],  xd[13]);
        qr(xd[3], xd[4], xd[9],  xd[14]);
        for (int k = 0; k < 16; k++) blk[32*k +: 32] = s_reg[k] + i_reg[k];
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            for (int k = 0; k < 16; k++) begin
                s_reg[k] <= init[k];
                i_reg[k] <= init[k];
            end
        end else if (busy_reg) begin
            // even rounds work on columns, odd rounds on diagonals
            for (int k = 0; k < 16; k++) s_reg[k] <= rnd_reg[0] ? xd[k] : xc[k];
        end
        if (!aresetn) begin
            busy_reg <= 1'b0;
            rnd_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            if (start) begin
                busy_reg <= 1'b1;
                rnd_reg  <= '0;
                done_reg <= 1'b0;
            end else if (busy_reg) begin
                rnd_reg <= rnd_reg + 5'd1;
                if (rnd_reg == 5'd19) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end else begin
                    done_reg <= 1'b0;
                end
            end else begin
                done_reg <= 1'b0;
            end
        end
    end

endmodule

// ----- rtl/cc20d_back.sv -----
// sequencer: applies entropy, lazy seed, keystream output and key erasure
module cc20d_back (
    input  logic            aclk,
    input  logic            aresetn,
    input  cc20d_pkg::cmd_t q_data,
    input  logic            q_valid,
    output logic            q_ready,
    output logic            m_tvalid,
    input  logic            m_tready,
    output logic [39:0]     m_tdata,
    output logic            m_tlast
);

    typedef enum logic [2:0] {
        ST_IDLE, ST_MIX, ST_GEN, ST_OUT, ST_ERASE
    } state_t;

    state_t       st_reg;
    logic [255:0] key_reg;
    logic [63:0]  ctr_reg;
    logic         seeded_reg;
    logic [4:0]   pos_reg;
    logic         mark_reg;
    logic         gen_reg;
    logic [8:0]   left_reg;
    logic [3:0]   w_reg;
    logic [511:0] blk_reg;
    logic         start_reg;
    logic         have_reg;
    logic         out_valid_reg;
    logic [39:0]  out_data_reg;
    logic         out_last_reg;
    logic         done;
    logic [511:0] blk;
    logic [255:0] key_x;
    logic [31:0]  word;
    logic [2:0]   cnt;
    logic         launch;
    logic         emit;

    cc20d_core u_core (
        .aclk(aclk), .aresetn(aresetn), .start(start_reg), .key(key_reg),
        .ctr(ctr_reg), .done(done), .blk(blk)
    );

    assign q_ready  = (st_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

    // next word goes out once the block is in and the output register is free
    assign emit = (st_reg == ST_OUT) && have_reg && (!out_valid_reg || m_tready);

    always_comb begin
        key_x = key_reg;
        key_x[{pos_reg, 3'b000} +: 8] = key_reg[{pos_reg, 3'b000} +: 8] ^ q_data.ebyte;
        cnt  = (left_reg < 9'd4) ? left_reg[2:0] : 3'd4;
        word = blk_reg[{w_reg, 5'b00000} +: 32];
        case (cnt)
            3'd1:    word = word & 32'h000000ff;
            3'd2:    word = word & 32'h0000ffff;
            3'd3:    word = word & 32'h00ffffff;
            default: word = word;
        endcase
        case (st_reg)
            ST_IDLE: launch = q_valid && ((q_data.gen == cc20d_pkg::CMD_FOLD) ?
                              q_data.elast : !seeded_reg);
            ST_GEN:  launch = 1'b1;
            default: launch = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg        <= ST_IDLE;
            key_reg       <= '0;
            ctr_reg       <= '0;
            seeded_reg    <= 1'b0;
            pos_reg       <= '0;
            start_reg     <= 1'b0;
            have_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            start_reg <= launch;
            // every block advances the counter once it completes
            if (done) ctr_reg <= ctr_reg + 64'd1;
            if (emit) begin
                out_valid_reg <= 1'b1;
            end else if (out_valid_reg && m_tready) begin
                out_valid_reg <= 1'b0;
            end
            case (st_reg)
                ST_IDLE: if (q_valid) begin
                    left_reg <= q_data.nbytes;
                    if (q_data.gen == cc20d_pkg::CMD_FOLD) begin
                        key_reg <= key_x;
                        pos_reg <= q_data.elast ? 5'd0 : pos_reg + 5'd1;
                        if (q_data.elast) begin
                            mark_reg <= q_data.emark;
                            gen_reg  <= 1'b0;
                            st_reg   <= ST_MIX;
                        end
                    end else if (!seeded_reg) begin
                        key_reg[31:0] <= key_reg[31:0] ^ q_data.tick;
                        mark_reg <= 1'b1;
                        gen_reg  <= 1'b1;
                        st_reg   <= ST_MIX;
                    end else begin
                        st_reg <= ST_GEN;
                    end
                end
                ST_MIX: if (done) begin
                    key_reg <= key_reg ^ blk[255:0];
                    if (mark_reg) seeded_reg <= 1'b1;
                    st_reg <= gen_reg ? ST_GEN : ST_IDLE;
                end
                ST_GEN: begin
                    have_reg <= 1'b0;
                    w_reg    <= '0;
                    st_reg   <= (left_reg == 9'd0) ? ST_ERASE : ST_OUT;
                end
                ST_OUT: if (done) begin
                    blk_reg  <= blk;
                    have_reg <= 1'b1;
                end else if (emit) begin
                    out_data_reg <= {5'b0, cnt, word};
                    out_last_reg <= (left_reg == 9'(cnt));
                    left_reg     <= left_reg - 9'(cnt);
                    w_reg        <= w_reg + 4'd1;
                    if (left_reg == 9'(cnt) || w_reg == 4'd15) begin
                        st_reg <= ST_GEN;
                    end
                end
                ST_ERASE: if (done) begin
                    key_reg <= blk[255:0];
                    st_reg  <= ST_IDLE;
                end
                default: st_reg <= ST_IDLE;
            endcase
        end
    end

    a_outst: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> m_tvalid)
        else $error("result dropped while stalled");
    a_qrdy: assert property (@(posedge aclk) disable iff (!aresetn)
        q_ready |-> (st_reg == ST_IDLE))
        else $error("queue popped while busy");
    a_cnt: assert property (@(posedge aclk) disable iff (!aresetn)
        (st_reg == ST_OUT) |-> (left_reg != 9'd0))
        else $error("output state with nothing left");

endmodule
